FILE: rtl/sll_pkg.sv
// Shared types and constants for the static linked list engine.
package sll_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths of the stream items.
  localparam int POS_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int LEN_W    = 10;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;

  // Packed tdata widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOFREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_RD,
    S_WALK,
    S_VIC_RD,
    S_WR_A,
    S_WR_B,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

FILE: rtl/sll_link_mem.sv
// Link memory: one write port, one read port with registered read data.
module sll_link_mem #(
  parameter int DEPTH = sll_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [$clog2(DEPTH)-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_data
);

  logic [$clog2(DEPTH)-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/sll_data_mem.sv
// Data memory: holds the value of each occupied slot.
module sll_data_mem #(
  parameter int DEPTH      = sll_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]    wr_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

FILE: rtl/sll_ctrl.sv
// Sequencer: clearing pass, list walk and relinking over the link memory.
module sll_ctrl #(
  parameter int DEPTH      = sll_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item side
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         item_cmd,
  input  logic [sll_pkg::POS_W-1:0]    item_pos,
  input  logic [sll_pkg::VALUE_W-1:0]  item_value,
  // result side
  output logic                         res_valid,
  input  logic                         res_ready,
  output sll_pkg::result_t             res,
  // link memory
  output logic [$clog2(DEPTH)-1:0]     lk_rd_addr,
  input  logic [$clog2(DEPTH)-1:0]     lk_rd_data,
  output logic                         lk_wr_en,
  output logic [$clog2(DEPTH)-1:0]     lk_wr_addr,
  output logic [$clog2(DEPTH)-1:0]     lk_wr_data,
  // data memory
  output logic                         dt_wr_en,
  output logic [$clog2(DEPTH)-1:0]     dt_wr_addr,
  output logic [DATA_WIDTH-1:0]        dt_wr_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = ((AW > sll_pkg::POS_W) ? AW : sll_pkg::POS_W) + 1;
  localparam logic [AW-1:0] HEAD     = AW'(DEPTH - 1);
  localparam logic [AW-1:0] FREE_END = AW'(DEPTH - 2);

  sll_pkg::state_t           state_r, state_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [AW-1:0]             free_head_r, free_head_nxt;
  logic [AW-1:0]             count_r, count_nxt;
  logic                      cmd_r, cmd_nxt;
  logic [sll_pkg::POS_W-1:0] steps_r, steps_nxt;
  logic [AW-1:0]             cur_r, cur_nxt;
  logic [AW-1:0]             pn_r, pn_nxt;
  logic [AW-1:0]             fnext_r, fnext_nxt;
  logic [AW-1:0]             slot_r, slot_nxt;
  sll_pkg::status_t          status_r, status_nxt;

  logic [CMPW-1:0] pos_x, cnt_x;
  logic            ins_ok, del_ok;

  assign pos_x  = CMPW'(item_pos);
  assign cnt_x  = CMPW'(count_r);
  assign ins_ok = (item_pos != '0) && (pos_x <= cnt_x + CMPW'(1));
  assign del_ok = (item_pos != '0) && (pos_x <= cnt_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sll_pkg::S_CLEAR;
      clr_r       <= '0;
      free_head_r <= AW'(1);
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    steps_r  <= steps_nxt;
    cur_r    <= cur_nxt;
    pn_r     <= pn_nxt;
    fnext_r  <= fnext_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    steps_nxt     = steps_r;
    cur_nxt       = cur_r;
    pn_nxt        = pn_r;
    fnext_nxt     = fnext_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    item_ready    = 1'b0;
    res_valid     = 1'b0;
    lk_rd_addr    = cur_r;
    lk_wr_en      = 1'b0;
    lk_wr_addr    = cur_r;
    lk_wr_data    = free_head_r;
    dt_wr_en      = 1'b0;
    dt_wr_addr    = free_head_r;
    dt_wr_data    = DATA_WIDTH'(item_value);

    unique case (state_r)
      sll_pkg::S_CLEAR: begin
        // Link every slot to the next; close the free chain and the data list.
        lk_wr_en   = 1'b1;
        lk_wr_addr = clr_r;
        lk_wr_data = (clr_r == FREE_END || clr_r == HEAD) ? '0 : clr_r + AW'(1);
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == HEAD) begin
          state_nxt = sll_pkg::S_IDLE;
        end
      end
      sll_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd_nxt    = item_cmd;
          steps_nxt  = item_pos - sll_pkg::POS_W'(1);
          slot_nxt   = '0;
          status_nxt = sll_pkg::ST_DONE;
          if (item_cmd == sll_pkg::CMD_INSERT) begin
            if (!ins_ok) begin
              status_nxt = sll_pkg::ST_RANGE;
              state_nxt  = sll_pkg::S_DONE;
            end else if (free_head_r == '0) begin
              status_nxt = sll_pkg::ST_NOFREE;
              state_nxt  = sll_pkg::S_DONE;
            end else begin
              // Store the value now; fetch the link of the fresh slot.
              dt_wr_en   = 1'b1;
              lk_rd_addr = free_head_r;
              state_nxt  = sll_pkg::S_FREE_RD;
            end
          end else begin
            if (!del_ok) begin
              status_nxt = sll_pkg::ST_RANGE;
              state_nxt  = sll_pkg::S_DONE;
            end else begin
              lk_rd_addr = HEAD;
              cur_nxt    = HEAD;
              state_nxt  = sll_pkg::S_WALK;
            end
          end
        end
      end
      sll_pkg::S_FREE_RD: begin
        fnext_nxt  = lk_rd_data;
        lk_rd_addr = HEAD;
        cur_nxt    = HEAD;
        state_nxt  = sll_pkg::S_WALK;
      end
      sll_pkg::S_WALK: begin
        // One link a cycle; the read data addresses the next read directly.
        if (steps_r == '0) begin
          pn_nxt = lk_rd_data;
          if (cmd_r == sll_pkg::CMD_INSERT) begin
            state_nxt = sll_pkg::S_WR_A;
          end else begin
            lk_rd_addr = lk_rd_data;
            state_nxt  = sll_pkg::S_VIC_RD;
          end
        end else begin
          cur_nxt    = lk_rd_data;
          lk_rd_addr = lk_rd_data;
          steps_nxt  = steps_r - sll_pkg::POS_W'(1);
        end
      end
      sll_pkg::S_VIC_RD: begin
        // Unlink: predecessor takes the victim's successor.
        lk_wr_en   = 1'b1;
        lk_wr_addr = cur_r;
        lk_wr_data = lk_rd_data;
        state_nxt  = sll_pkg::S_WR_B;
      end
      sll_pkg::S_WR_A: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = free_head_r;
        lk_wr_data = pn_r;
        state_nxt  = sll_pkg::S_WR_B;
      end
      sll_pkg::S_WR_B: begin
        lk_wr_en   = 1'b1;
        lk_wr_data = free_head_r;
        if (cmd_r == sll_pkg::CMD_INSERT) begin
          lk_wr_addr    = cur_r;
          slot_nxt      = free_head_r;
          free_head_nxt = fnext_r;
          count_nxt     = count_r + AW'(1);
        end else begin
          // Push the victim onto the free chain.
          lk_wr_addr    = pn_r;
          slot_nxt      = pn_r;
          free_head_nxt = pn_r;
          count_nxt     = count_r - AW'(1);
        end
        state_nxt = sll_pkg::S_DONE;
      end
      sll_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = sll_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sll_pkg::S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.length = sll_pkg::LEN_W'(count_r);
  assign res.slot   = sll_pkg::SLOT_W'(slot_r);

endmodule

FILE: rtl/static_linked_list_engine.sv
// Top level of the static linked list engine with free chain.
//
//   channel | direction | tdata (low bit up)        | tuser
//   in_     | input     | position[9:0] value[41:10] | cmd
//   out_    | output    | length[9:0] slot[19:10]    | status
//
// The time a successful insert or delete takes is set by its position and
// by the walk that follows one link per cycle through the link memory.
// An item refused for range or for an empty free chain skips the walk.
// After reset a clearing pass links the free chain; no item is taken
// meanwhile. A stalled result waits in the output register while the
// next item is taken and worked on.
module static_linked_list_engine #(
  parameter int DEPTH      = sll_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sll_pkg::IN_TDATA_W-1:0]  in_tdata,   // position, value
  input  logic                            in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sll_pkg::OUT_TDATA_W-1:0] out_tdata,  // length, slot
  output logic [sll_pkg::STATUS_W-1:0]    out_tuser   // status
);

  localparam int AW = $clog2(DEPTH);

  logic                 res_valid, res_ready;
  sll_pkg::result_t     res;
  logic [AW-1:0]        lk_rd_addr, lk_rd_data, lk_wr_addr, lk_wr_data;
  logic                 lk_wr_en;
  logic                 dt_wr_en;
  logic [AW-1:0]        dt_wr_addr;
  logic [DATA_WIDTH-1:0] dt_wr_data;

  logic                 out_valid_r, out_valid_nxt;
  sll_pkg::result_t     out_res_r;

  sll_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_cmd   (in_tuser),
    .item_pos   (in_tdata[sll_pkg::POS_W-1:0]),
    .item_value (in_tdata[sll_pkg::POS_W +: sll_pkg::VALUE_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .lk_rd_addr (lk_rd_addr),
    .lk_rd_data (lk_rd_data),
    .lk_wr_en   (lk_wr_en),
    .lk_wr_addr (lk_wr_addr),
    .lk_wr_data (lk_wr_data),
    .dt_wr_en   (dt_wr_en),
    .dt_wr_addr (dt_wr_addr),
    .dt_wr_data (dt_wr_data)
  );

  sll_link_mem #(
    .DEPTH (DEPTH)
  ) u_link_mem (
    .clk     (clk),
    .rd_addr (lk_rd_addr),
    .rd_data (lk_rd_data),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data)
  );

  sll_data_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_data_mem (
    .clk     (clk),
    .wr_en   (dt_wr_en),
    .wr_addr (dt_wr_addr),
    .wr_data (dt_wr_data)
  );

  // Output register: take a new result whenever the slot is empty or draining.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0, out_res_r.slot, out_res_r.length};

  // The sequencer never takes an item while it offers a result.
  a_ready_vs_result : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && res_valid))
    else $error("item taken while a result is pending");

  // A refused item reports slot zero.
  a_err_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.status != sll_pkg::ST_DONE) |-> out_res_r.slot == '0)
    else $error("refused item reports a slot");

  // A successful item never hands out slot zero or the list head (checked for DEPTH up to 1024).
  a_ok_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == sll_pkg::ST_DONE) |->
      (DEPTH > 1024) || (res.slot != '0 && res.slot != sll_pkg::SLOT_W'(DEPTH - 1)))
    else $error("reserved slot used");

  // A result leaves the output register only when taken.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped before being taken");

endmodule

FILE: verif/tb_static_linked_list_engine.sv
// Self-checking testbench for the static linked list engine.
`timescale 1ns / 1ps

module tb_static_linked_list_engine;

  localparam int LIST_DEPTH = sll_pkg::DEPTH_DEF;
  localparam int DATA_HEAD  = LIST_DEPTH - 1;
  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD   = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sll_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sll_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [sll_pkg::STATUS_W-1:0] out_tuser;

  typedef struct {
    sll_pkg::cmd_t    op;
    int unsigned      pos;
    logic [31:0]      value;
    bit               typed;
    sll_pkg::status_t st;
    int unsigned      len;
    int unsigned      slot;
  } list_step_t;

  // Rows with typed results follow directly from the reset free chain.
  list_step_t directed_steps [23] = '{
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b1, sll_pkg::ST_RANGE, 0, 0},
    '{sll_pkg::CMD_INSERT, 0,    32'h0000_0000, 1'b1, sll_pkg::ST_RANGE, 0, 0},
    '{sll_pkg::CMD_INSERT, 2,    32'h0000_0000, 1'b1, sll_pkg::ST_RANGE, 0, 0},
    '{sll_pkg::CMD_INSERT, 1,    32'h0000_0000, 1'b1, sll_pkg::ST_DONE,  1, 1},
    '{sll_pkg::CMD_INSERT, 1023, 32'hffff_ffff, 1'b1, sll_pkg::ST_RANGE, 1, 0},
    '{sll_pkg::CMD_INSERT, 2,    32'hffff_ffff, 1'b1, sll_pkg::ST_DONE,  2, 2},
    '{sll_pkg::CMD_DELETE, 0,    32'h0000_0000, 1'b1, sll_pkg::ST_RANGE, 2, 0},
    '{sll_pkg::CMD_DELETE, 3,    32'h0000_0000, 1'b1, sll_pkg::ST_RANGE, 2, 0},
    '{sll_pkg::CMD_DELETE, 1023, 32'hffff_ffff, 1'b1, sll_pkg::ST_RANGE, 2, 0},
    '{sll_pkg::CMD_INSERT, 1,    32'ha5a5_a5a5, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_INSERT, 2,    32'h5a5a_5a5a, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_INSERT, 5,    32'h1234_5678, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 5,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 2,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_INSERT, 1,    32'h8000_0001, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_INSERT, 3,    32'h7fff_fffe, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b0, sll_pkg::ST_DONE,  0, 0},
    '{sll_pkg::CMD_DELETE, 1,    32'h0000_0000, 1'b1, sll_pkg::ST_RANGE, 0, 0},
    '{sll_pkg::CMD_INSERT, 1,    32'hdead_beef, 1'b0, sll_pkg::ST_DONE,  0, 0}
  };

  // Shadow of the link array and element counter
  int unsigned next_link [LIST_DEPTH];
  int unsigned list_len;

  sll_pkg::result_t pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  static_linked_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic sll_pkg::result_t apply_list_op(sll_pkg::cmd_t op,
                                                     logic [sll_pkg::POS_W-1:0] pos);
    sll_pkg::result_t res;
    int unsigned      fresh;
    int unsigned      prev;
    int unsigned      victim;
    res.status = sll_pkg::ST_DONE;
    res.slot   = '0;
    if (op == sll_pkg::CMD_INSERT) begin
      if (pos == 0 || pos > list_len + 1) begin
        res.status = sll_pkg::ST_RANGE;
      end else begin
        fresh = next_link[0];
        if (fresh == 0 || fresh >= DATA_HEAD) begin
          res.status = sll_pkg::ST_NOFREE;
        end else begin
          next_link[0] = next_link[fresh];
          prev = DATA_HEAD;
          for (int k = 1; k < pos; k++) prev = next_link[prev];
          next_link[fresh] = next_link[prev];
          next_link[prev] = fresh;
          list_len++;
          res.slot = sll_pkg::SLOT_W'(fresh);
        end
      end
    end else begin
      if (pos == 0 || pos > list_len) begin
        res.status = sll_pkg::ST_RANGE;
      end else begin
        prev = DATA_HEAD;
        for (int k = 1; k < pos; k++) prev = next_link[prev];
        victim = next_link[prev];
        if (victim == 0 || victim >= DATA_HEAD) begin
          res.status = sll_pkg::ST_RANGE;
        end else begin
          next_link[prev] = next_link[victim];
          next_link[victim] = next_link[0];
          next_link[0] = victim;
          list_len--;
          res.slot = sll_pkg::SLOT_W'(victim);
        end
      end
    end
    res.length = sll_pkg::LEN_W'(list_len);
    return res;
  endfunction

  task automatic send_item(sll_pkg::cmd_t op, logic [sll_pkg::POS_W-1:0] pos,
                           logic [31:0] value, bit typed,
                           sll_pkg::result_t typed_res);
    int unsigned      gap;
    sll_pkg::result_t predicted;
    gap = 0;
    while ($urandom_range(99) < tx_gap_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(sll_pkg::IN_TDATA_W - sll_pkg::POS_W - sll_pkg::VALUE_W){1'b0}},
                  value, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_list_op(op, pos);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Receiver: check each item, then choose next cycle's ready
  always @(posedge clk) begin
    sll_pkg::result_t want;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d length %0d slot %0d",
                 $time, out_tuser, out_tdata[sll_pkg::LEN_W-1:0],
                 out_tdata[sll_pkg::LEN_W+sll_pkg::SLOT_W-1:sll_pkg::LEN_W]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[sll_pkg::LEN_W-1:0] !== want.length) begin
          $display("%0t: length mismatch: expected %0d actual %0d",
                   $time, want.length, out_tdata[sll_pkg::LEN_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[sll_pkg::LEN_W+sll_pkg::SLOT_W-1:sll_pkg::LEN_W] !== want.slot) begin
          $display("%0t: slot mismatch: expected %0d actual %0d",
                   $time, want.slot,
                   out_tdata[sll_pkg::LEN_W+sll_pkg::SLOT_W-1:sll_pkg::LEN_W]);
          mismatch_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("static_linked_list_engine test failed");
      $finish;
    end
  end

  initial begin
    int unsigned      n;
    int unsigned      r;
    int unsigned      grow_to;
    int unsigned      pos;
    sll_pkg::cmd_t    op;
    sll_pkg::result_t typed_res;

    for (int i = 0; i < LIST_DEPTH; i++) next_link[i] = i + 1;
    next_link[LIST_DEPTH-2] = 0;
    next_link[LIST_DEPTH-1] = 0;
    list_len = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_pct = 14;
    rx_stall_pct = 71;
    foreach (directed_steps[i]) begin
      typed_res.status = directed_steps[i].st;
      typed_res.length = sll_pkg::LEN_W'(directed_steps[i].len);
      typed_res.slot   = sll_pkg::SLOT_W'(directed_steps[i].slot);
      send_item(directed_steps[i].op, sll_pkg::POS_W'(directed_steps[i].pos),
                directed_steps[i].value, directed_steps[i].typed, typed_res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct = 14; rx_stall_pct = 71; grow_to = 6;
        end
        1: begin
          tx_gap_pct = 71; rx_stall_pct = 14; grow_to = 40;
        end
        default: begin
          tx_gap_pct = 0; rx_stall_pct = 0; grow_to = 150;
        end
      endcase
      for (n = 0; n < 150; n++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // Out-of-range noise, including position zero
          op = $urandom_range(1) ? sll_pkg::CMD_DELETE : sll_pkg::CMD_INSERT;
          pos = ($urandom_range(3) == 0) ? 0 :
                $urandom_range(1023, list_len + ((op == sll_pkg::CMD_INSERT) ? 2 : 1));
        end else if (list_len == 0 || r < ((list_len < grow_to) ? 60 : 40)) begin
          op = sll_pkg::CMD_INSERT;
          pos = $urandom_range(1, list_len + 1);
        end else begin
          op = sll_pkg::CMD_DELETE;
          pos = $urandom_range(1, list_len);
        end
        send_item(op, sll_pkg::POS_W'(pos), $urandom, 1'b0, typed_res);
      end
    end

    // Drain completely, then stall the receiver while items keep coming
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    hold_asked++;
    for (n = 0; n < 60; n++) begin
      pos = ($urandom_range(9) == 0) ? list_len + 1 :
            $urandom_range(1, (list_len + 1 < 4) ? list_len + 1 : 4);
      send_item(sll_pkg::CMD_INSERT, sll_pkg::POS_W'(pos), $urandom, 1'b0, typed_res);
    end

    // Positions at the ends of the list and just beyond
    send_item(sll_pkg::CMD_INSERT, 1, $urandom, 1'b0, typed_res);
    send_item(sll_pkg::CMD_INSERT, sll_pkg::POS_W'(list_len + 1), $urandom, 1'b0,
              typed_res);
    send_item(sll_pkg::CMD_INSERT, 0, $urandom, 1'b0, typed_res);
    send_item(sll_pkg::CMD_DELETE, sll_pkg::POS_W'(list_len + 1), $urandom, 1'b0,
              typed_res);
    send_item(sll_pkg::CMD_DELETE, sll_pkg::POS_W'(list_len), $urandom, 1'b0, typed_res);
    send_item(sll_pkg::CMD_INSERT, sll_pkg::POS_W'(list_len + 1), $urandom, 1'b0,
              typed_res);
    send_item(sll_pkg::CMD_INSERT, 2, $urandom, 1'b0, typed_res);
    send_item(sll_pkg::CMD_DELETE, 1, $urandom, 1'b0, typed_res);
    for (n = 0; n < 40; n++) begin
      pos = ($urandom_range(19) == 0) ? $urandom_range(1, list_len) :
            $urandom_range(1, 6);
      send_item(($urandom_range(3) == 0) ? sll_pkg::CMD_INSERT : sll_pkg::CMD_DELETE,
                sll_pkg::POS_W'(pos), $urandom, 1'b0, typed_res);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("static_linked_list_engine test passed");
    end else begin
      $display("static_linked_list_engine test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sll_pkg.sv
rtl/sll_link_mem.sv
rtl/sll_data_mem.sv
rtl/sll_ctrl.sv
rtl/static_linked_list_engine.sv
verif/tb_static_linked_list_engine.sv
